// ===== rtl/core/itc_pkg.sv =====
// ----------------------------------------------------------------------------
// itc_pkg: shared types and helpers for the interval timer channel
// Request kinds, divider handshake structs, mode codes and BCD conversion.
// ----------------------------------------------------------------------------
package itc_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CTRL  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // count mode codes
  localparam logic [2:0] MODE_TERM    = 3'd0;
  localparam logic [2:0] MODE_ONESHOT = 3'd1;
  localparam logic [2:0] MODE_RATE    = 3'd2;
  localparam logic [2:0] MODE_SQUARE  = 3'd3;
  localparam logic [2:0] MODE_SWSTB   = 3'd4;
  localparam logic [2:0] MODE_HWSTB   = 3'd5;

  // byte phase codes
  localparam logic [1:0] PH_MSB_LAST = 2'd0;
  localparam logic [1:0] PH_LSB      = 2'd1;
  localparam logic [1:0] PH_MSB      = 2'd2;
  localparam logic [1:0] PH_LSB_MSB  = 2'd3;

  localparam int unsigned CNT_W  = 17;
  localparam int unsigned PROD_W = 2 * CNT_W;

  localparam logic [16:0] FULL_RELOAD = 17'h10000;
  localparam logic [16:0] BCD_MAX     = 17'd9999;

  // reciprocals for exact division of 16-bit values by 10^k
  localparam logic [16:0] RECIP_10    = 17'd104858;  // >> 20
  localparam logic [16:0] RECIP_100   = 17'd83887;   // >> 23
  localparam logic [16:0] RECIP_1000  = 17'd67109;   // >> 26
  localparam logic [16:0] RECIP_10000 = 17'd107375;  // >> 30

  // divider request from the channel state
  typedef struct packed {
    logic        need;
    logic [16:0] reload;
    logic [16:0] rem;
    logic [16:0] len;
  } div_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } div_stat_t;

  // four low decimal digits of v, packed as BCD; higher digits drop
  function automatic logic [15:0] to_bcd(input logic [15:0] v);
    logic [32:0] m1, m2, m3, m4;
    logic [15:0] q1, q2, q3, q4;
    logic [15:0] d0, d1, d2, d3;
    m1 = 33'(v) * 33'(RECIP_10);
    m2 = 33'(v) * 33'(RECIP_100);
    m3 = 33'(v) * 33'(RECIP_1000);
    m4 = 33'(v) * 33'(RECIP_10000);
    q1 = 16'(m1 >> 20);
    q2 = 16'(m2 >> 23);
    q3 = 16'(m3 >> 26);
    q4 = 16'(m4 >> 30);
    d0 = v  - 16'(q1 * 16'd10);
    d1 = q1 - 16'(q2 * 16'd10);
    d2 = q2 - 16'(q3 * 16'd10);
    d3 = q3 - 16'(q4 * 16'd10);
    return {d3[3:0], d2[3:0], d1[3:0], d0[3:0]};
  endfunction

  // nibbles weighted as decimal digits, no digit check
  function automatic logic [15:0] from_bcd(input logic [15:0] v);
    return 16'(v[3:0]) + 16'(v[7:4]) * 16'd10 +
           16'(v[11:8]) * 16'd100 + 16'(v[15:12]) * 16'd1000;
  endfunction

endpackage

// ===== rtl/core/interval_timer_channel.sv =====
// ----------------------------------------------------------------------------
// interval_timer_channel: one channel of an 8254-style interval timer
// Tick, control, data write and data read requests in; read bytes out.
// ----------------------------------------------------------------------------
// Each request is a kind on in_tuser (0 tick, 1 control word, 2 data write,
// 3 data read) with its byte on in_tdata; only data reads return a byte on
// out_tdata. Requests are registered on entry and normally retire one per
// cycle, so a stream can run back to back. The exception is a count latch
// (a latch control word, or a read that relatches) in the rate or square
// wave modes outside just-set mode: the scaled count reload*remaining/period
// comes from a multiply plus a 34-step restoring divider, and that request
// holds in_tready low until the divider is done. Time is whole ticks;
// the elapsed counter is ELAPSED_BITS wide and saturates. Reads retire only
// when the output register is free or being drained in the same cycle.
module interval_timer_channel import itc_pkg::*; #(
  parameter int unsigned ELAPSED_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [1:0] opcode
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [7:0] read_byte
);

  // input register
  logic       item_valid_r;
  logic [1:0] item_op_r;
  logic [7:0] item_byte_r;
  // output register
  logic       out_valid_r;
  logic [7:0] out_data_r;

  op_t        item_op;
  logic       is_read;
  logic       out_free;
  logic       exec;
  logic       div_start;
  div_req_t   div_req;
  div_stat_t  div_stat;
  logic [15:0] quo;
  logic [7:0] read_byte;

  assign item_op  = op_t'(item_op_r);
  assign is_read  = (item_op == OP_READ);
  assign out_free = !out_valid_r || out_tready;

  // retire the held request: wait for any divider result and, for a read, a free output slot
  assign exec = item_valid_r && (!div_req.need || div_stat.done) &&
                (!is_read || out_free);
  assign div_start = item_valid_r && div_req.need && div_stat.idle;

  assign in_tready = !item_valid_r || exec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tready) item_valid_r <= in_tvalid;
      if (exec && is_read)  out_valid_r <= 1'b1;
      else if (out_tready)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_op_r   <= in_tuser;
      item_byte_r <= in_tdata;
    end
    if (exec && is_read) out_data_r <= read_byte;
  end

  itc_state #(
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .exec      (exec),
    .op        (item_op),
    .data_byte (item_byte_r),
    .quo       (quo),
    .div_req   (div_req),
    .read_byte (read_byte)
  );

  itc_scale_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .ack   (exec),
    .req   (div_req),
    .stat  (div_stat),
    .quo   (quo)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---- checks ----
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && is_read) |-> (!out_valid_r || out_tready))
    else $error("read retired over an untaken result");

  a_hold_for_div: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && div_req.need && !div_stat.done) |-> !in_tready)
    else $error("request taken while scaled count pending");

  a_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (item_valid_r && div_req.need))
    else $error("divider result without a waiting latch");

  a_read_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && is_read) |=> out_tvalid)
    else $error("retired read produced no result");

endmodule

// ===== rtl/core/itc_scale_div.sv =====
// ----------------------------------------------------------------------------
// itc_scale_div: scaled count for the periodic modes
// Computes reload * rem / len with one multiply and a radix-2 restoring divide.
// ----------------------------------------------------------------------------
module itc_scale_div import itc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        ack,
  input  div_req_t    req,
  output div_stat_t   stat,
  output logic [15:0] quo
);

  localparam int unsigned STEP_W = $clog2(PROD_W);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } div_state_t;

  div_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     reload_r, rem_r, len_r;
  logic [PROD_W-1:0]    dvd_r, dvd_nxt;
  logic [CNT_W:0]       prem_r, prem_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [CNT_W:0]       trial;
  logic                 fits;

  assign trial = {prem_r[CNT_W-1:0], dvd_r[PROD_W-1]};
  assign fits  = trial >= {1'b0, len_r};

  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    prem_nxt  = prem_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_MUL;
      end
      S_MUL: begin
        dvd_nxt   = reload_r * rem_r;
        prem_nxt  = '0;
        step_nxt  = STEP_W'(PROD_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        prem_nxt = fits ? (trial - {1'b0, len_r}) : trial;
        dvd_nxt  = {dvd_r[PROD_W-2:0], fits};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (ack) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      reload_r <= req.reload;
      rem_r    <= req.rem;
      len_r    <= req.len;
    end
    dvd_r  <= dvd_nxt;
    prem_r <= prem_nxt;
    step_r <= step_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign quo       = dvd_r[15:0];

endmodule

// ===== rtl/core/itc_state.sv =====
// ----------------------------------------------------------------------------
// itc_state: channel registers and per-request update
// Holds reload, phases, modes and elapsed counters; forms the read byte.
// ----------------------------------------------------------------------------
module itc_state import itc_pkg::*; #(
  parameter int unsigned ELAPSED_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        exec,
  input  op_t         op,
  input  logic [7:0]  data_byte,
  input  logic [15:0] quo,
  output div_req_t    div_req,
  output logic [7:0]  read_byte
);

  logic [16:0]             reload_r, reload_nxt;
  logic [15:0]             aw_r, aw_nxt;
  logic [15:0]             held_r, held_nxt;
  logic [2:0]              mode_r, mode_nxt;
  logic [1:0]              rphase_r, rphase_nxt;
  logic [1:0]              wphase_r, wphase_nxt;
  logic                    dec_r, dec_nxt;
  logic                    relatch_r, relatch_nxt;
  logic                    mjs_r, mjs_nxt;
  logic [ELAPSED_BITS-1:0] ticks_r, ticks_nxt;
  logic [16:0]             pphase_r, pphase_nxt;
  logic [15:0]             wrap_r, wrap_nxt;
  logic [16:0]             plen_r, plen_nxt;

  logic [ELAPSED_BITS-1:0] ticks_inc, len_ext;
  logic [17:0]             pp_inc;
  logic [16:0]             wrap_inc;
  logic [15:0]             wrap_step;
  logic [17:0]             dbl, p_sel;
  logic [15:0]             latch_val;
  logic                    past_term;
  logic                    latch_ctrl, latch_read;
  logic [15:0]             aw_src, aw_mid, aw_new;
  logic [1:0]              wp_new;
  logic [16:0]             reload_new;
  logic [15:0]             held_base, shown;
  logic [2:0]              mode_map;

  // ---- tick arithmetic ----
  assign len_ext   = ELAPSED_BITS'(plen_r);
  assign ticks_inc = (ticks_r != '1) ? ticks_r + 1'b1 : ticks_r;
  assign pp_inc    = {1'b0, pphase_r} + 18'd1;
  assign wrap_inc  = {1'b0, wrap_r} + 17'd1;
  assign wrap_step = (dec_r && wrap_inc >= 17'd10000) ? 16'd0 : wrap_inc[15:0];

  // ---- divider operands for the periodic modes ----
  assign dbl   = ({1'b0, pphase_r} << 1) > {1'b0, plen_r} ?
                 ({1'b0, pphase_r} << 1) - {1'b0, plen_r} : ({1'b0, pphase_r} << 1);
  assign p_sel = (mode_r == MODE_RATE) ? {1'b0, pphase_r} : dbl;

  assign latch_ctrl = (op == OP_CTRL) && (data_byte[7:6] == 2'b00);
  assign latch_read = (op == OP_READ) && relatch_r;

  always_comb begin
    div_req.need   = (latch_ctrl || latch_read) && !mjs_r &&
                     (mode_r == MODE_RATE || mode_r == MODE_SQUARE);
    div_req.reload = reload_r;
    div_req.len    = plen_r;
    div_req.rem    = (p_sel <= {1'b0, plen_r}) ? 17'(({1'b0, plen_r}) - p_sel) : '0;
  end

  // ---- latched count ----
  assign past_term = ticks_r > len_ext;

  always_comb begin
    latch_val = held_r;
    if (mjs_r) begin
      latch_val = held_r - ticks_r[15:0];
    end else begin
      case (mode_r)
        MODE_TERM, MODE_SWSTB: begin
          if (past_term) latch_val = dec_r ? 16'd9999 - wrap_r : 16'hffff - wrap_r;
          else           latch_val = reload_r[15:0] - ticks_r[15:0];
        end
        MODE_ONESHOT: latch_val = held_r;
        MODE_RATE:    latch_val = quo;
        MODE_SQUARE:  latch_val = quo & 16'hfffe;
        default:      latch_val = 16'hffff;
      endcase
    end
  end

  // ---- data write assembly ----
  assign aw_src = dec_r ? to_bcd(aw_r) : aw_r;

  always_comb begin
    aw_mid = aw_src;
    wp_new = wphase_r;
    unique case (wphase_r)
      PH_MSB_LAST: begin
        aw_mid = aw_src | {data_byte, 8'h00};
        wp_new = PH_LSB_MSB;
      end
      PH_LSB:  aw_mid = {8'h00, data_byte};
      PH_MSB:  aw_mid = {data_byte, 8'h00};
      default: begin
        aw_mid = {8'h00, data_byte};
        wp_new = PH_MSB_LAST;
      end
    endcase
  end

  assign aw_new     = dec_r ? from_bcd(aw_mid) : aw_mid;
  assign reload_new = (aw_new == '0) ? (dec_r ? BCD_MAX : FULL_RELOAD) : {1'b0, aw_new};

  // ---- read path ----
  assign held_base = relatch_r ? latch_val : held_r;
  assign shown     = dec_r ? to_bcd(held_base) : held_base;
  assign mode_map  = (data_byte[3:1] > MODE_HWSTB) ? data_byte[3:1] - 3'd4 : data_byte[3:1];

  always_comb begin
    read_byte = (rphase_r == PH_LSB || rphase_r == PH_LSB_MSB) ? shown[7:0] : shown[15:8];
  end

  // ---- next state ----
  always_comb begin
    reload_nxt  = reload_r;
    aw_nxt      = aw_r;
    held_nxt    = held_r;
    mode_nxt    = mode_r;
    rphase_nxt  = rphase_r;
    wphase_nxt  = wphase_r;
    dec_nxt     = dec_r;
    relatch_nxt = relatch_r;
    mjs_nxt     = mjs_r;
    ticks_nxt   = ticks_r;
    pphase_nxt  = pphase_r;
    wrap_nxt    = wrap_r;
    plen_nxt    = plen_r;
    if (exec) begin
      unique case (op)
        OP_TICK: begin
          ticks_nxt  = ticks_inc;
          pphase_nxt = (pp_inc >= {1'b0, plen_r}) ? '0 : pp_inc[16:0];
          if (ticks_inc > len_ext) wrap_nxt = wrap_step;
        end
        OP_CTRL: begin
          if (latch_ctrl) begin
            held_nxt    = latch_val;
            relatch_nxt = 1'b0;
            if (data_byte[5:4] != 2'b00) begin
              dec_nxt = data_byte[0];
              if (data_byte[0] && reload_r >= BCD_MAX) reload_nxt = BCD_MAX;
              ticks_nxt   = '0;
              pphase_nxt  = '0;
              wrap_nxt    = '0;
              relatch_nxt = 1'b1;
              rphase_nxt  = data_byte[5:4];
              wphase_nxt  = data_byte[5:4];
              mode_nxt    = mode_map;
              mjs_nxt     = 1'b1;
            end
          end
        end
        OP_WRITE: begin
          aw_nxt     = aw_new;
          wphase_nxt = wp_new;
          if (wp_new != PH_MSB_LAST) begin
            reload_nxt = reload_new;
            // a rate-mode rewrite keeps the running period
            if (mjs_r || mode_r != MODE_RATE) begin
              ticks_nxt  = '0;
              pphase_nxt = '0;
              wrap_nxt   = '0;
              plen_nxt   = reload_new;
              mjs_nxt    = 1'b0;
            end
          end
        end
        default: begin
          held_nxt    = dec_r ? from_bcd(shown) : held_base;
          relatch_nxt = 1'b0;
          unique case (rphase_r)
            PH_MSB_LAST: begin
              rphase_nxt  = PH_LSB_MSB;
              relatch_nxt = 1'b1;
            end
            PH_LSB:  relatch_nxt = 1'b1;
            PH_MSB:  relatch_nxt = 1'b1;
            default: rphase_nxt  = PH_MSB_LAST;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r  <= FULL_RELOAD;
      aw_r      <= '0;
      held_r    <= '0;
      mode_r    <= MODE_SQUARE;
      rphase_r  <= PH_LSB_MSB;
      wphase_r  <= PH_LSB_MSB;
      dec_r     <= 1'b0;
      relatch_r <= 1'b1;
      mjs_r     <= 1'b0;
      ticks_r   <= '0;
      pphase_r  <= '0;
      wrap_r    <= '0;
      plen_r    <= FULL_RELOAD;
    end else begin
      reload_r  <= reload_nxt;
      aw_r      <= aw_nxt;
      held_r    <= held_nxt;
      mode_r    <= mode_nxt;
      rphase_r  <= rphase_nxt;
      wphase_r  <= wphase_nxt;
      dec_r     <= dec_nxt;
      relatch_r <= relatch_nxt;
      mjs_r     <= mjs_nxt;
      ticks_r   <= ticks_nxt;
      pphase_r  <= pphase_nxt;
      wrap_r    <= wrap_nxt;
      plen_r    <= plen_nxt;
    end
  end

endmodule
